// ----- rtl/ntpm_pkg.sv -----
// Package: shared constants and types for the nearest-time packet matcher
`timescale 1ns / 1ps
package ntpm_pkg;
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SPEED_W     = 24;
    localparam int TIME_W      = 48;
    localparam int TOL_W       = 16;
    localparam int WIN_W       = 24;
    localparam int LAT_W       = 25;

    localparam logic [1:0] ST_RECORDED = 2'd0;
    localparam logic [1:0] ST_MATCHED  = 2'd1;
    localparam logic [1:0] ST_NO_MATCH = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic CMD_SENT = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    // config register indexes
    localparam logic [0:0] REG_TOL = 1'b0;
    localparam logic [0:0] REG_WIN = 1'b1;

    // search token passed down the cell row
    typedef struct packed {
        logic                      found;
        logic [IDX_W-1:0]          best;
        logic [TIME_W-1:0]         best_diff;
        logic [TIME_W-1:0]         best_time;
    } srch_t;
endpackage

// ----- rtl/nearest_time_packet_matcher_unit.sv -----
// Top level: nearest-time packet matcher, sent-packet table as a row of cells
`timescale 1ns / 1ps
// Usage:
//  s_ channel carries events (cmd, speed, event_time_us); m_ carries one
//  result per request. A send request writes the next free cell, if any,
//  and returns through the output register. A receive request launches a
//  search token down the row of TABLE_DEPTH cells; each cell registers the
//  token, so a search runs the full length of the cell row.
//  One request is in flight at a time; the next is taken once the result
//  register is free or being drained in the same cycle.
//  Configuration: cfg_we/cfg_idx/cfg_data, written while idle.
//  Reset clears the fill count and the handshake state; slot contents are
//  left as they were and are only read below the fill count.
//  When the receiver stalls, the result holds in the output register and
//  no new request is taken.
module nearest_time_packet_matcher_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [0:0]                         cfg_idx,
    input  logic [ntpm_pkg::WIN_W-1:0]         cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_cmd,
    input  logic signed [ntpm_pkg::SPEED_W-1:0] s_speed,
    input  logic [ntpm_pkg::TIME_W-1:0]        s_event_time_us,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic [7:0]                         m_entry_index,
    output logic signed [ntpm_pkg::LAT_W-1:0]  m_latency_us,
    output logic [ntpm_pkg::TIME_W-1:0]        m_sent_time_us
);
    import ntpm_pkg::*;

    logic [TOL_W-1:0]   tol_reg;
    logic [WIN_W-1:0]   win_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic               busy_reg;      // search running
    logic [CNT_W-1:0]   step_reg;      // cycles since launch
    logic signed [SPEED_W-1:0] rx_speed_reg;
    logic [TIME_W-1:0]  rx_time_reg;

    logic               m_valid_reg;
    logic [1:0]         status_reg;
    logic [7:0]         index_reg;
    logic [LAT_W-1:0]   lat_reg;
    logic [TIME_W-1:0]  sent_reg;

    srch_t              tok [TABLE_DEPTH+1];
    logic               accept, launch, finish, full;
    logic [TIME_W-1:0]  lat_full;
    srch_t              res;

    assign s_ready = !busy_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign launch  = accept && s_cmd != CMD_SENT;
    assign full    = fill_reg == CNT_W'(TABLE_DEPTH);
    assign res     = tok[TABLE_DEPTH];
    // finish once the token has left the last cell
    assign finish  = busy_reg && step_reg == CNT_W'(TABLE_DEPTH);
    assign lat_full = rx_time_reg - res.best_time;

    // launch token: search valid while rx registers hold; first cell sees
    // it the cycle after launch
    always_comb begin
        tok[0] = '0;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic [IDX_W-1:0] idx;
            logic             in_win;
            assign idx = IDX_W'(g);
            // cell g evaluates at step g, when the token arrives at it
            assign in_win = busy_reg && step_reg == CNT_W'(g)
                            && CNT_W'(g) < fill_reg;
            ntpm_cell u_cell (
                .aclk        (aclk),
                .wr_en       (accept && s_cmd == CMD_SENT && !full
                              && fill_reg[IDX_W-1:0] == idx),
                .wr_speed    (s_speed),
                .wr_time     (s_event_time_us),
                .set_matched (finish && res.found
                              && res.best_diff < TIME_W'(win_reg) && res.best == idx),
                .eval_en     (in_win),
                .my_idx      (idx),
                .rx_speed    (rx_speed_reg),
                .rx_time     (rx_time_reg),
                .tol         (tol_reg),
                .tok_in      (tok[g]),
                .tok_out     (tok[g+1])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg     <= TOL_W'(102);
            win_reg     <= WIN_W'(2000000);
            fill_reg    <= '0;
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_TOL: tol_reg <= cfg_data[TOL_W-1:0];
                    REG_WIN: win_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (launch) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (finish) begin
                busy_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
            end
            if (accept && s_cmd == CMD_SENT) begin
                m_valid_reg <= 1'b1;
                if (!full) fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // the token written into cell g at step g leaves it at the next step, so
    // cell g must see tok[g] carrying the decisions of cells below g: a
    // token entering cell 0 at step 0 reaches cell g at step g.

    always_ff @(posedge aclk) begin
        if (launch) begin
            rx_speed_reg <= s_speed;
            rx_time_reg  <= s_event_time_us;
        end
        if (accept && s_cmd == CMD_SENT) begin
            status_reg <= full ? ST_FULL : ST_RECORDED;
            index_reg  <= full ? 8'd0 : 8'(fill_reg);
            lat_reg    <= '0;
            sent_reg   <= '0;
        end else if (finish) begin
            if (res.found && res.best_diff < TIME_W'(win_reg)) begin
                status_reg <= ST_MATCHED;
                index_reg  <= 8'(res.best);
                lat_reg    <= lat_full[LAT_W-1:0];
                sent_reg   <= res.best_time;
            end else begin
                status_reg <= ST_NO_MATCH;
                index_reg  <= 8'd0;
                lat_reg    <= '0;
                sent_reg   <= '0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_entry_index  = index_reg;
    assign m_latency_us   = lat_reg;
    assign m_sent_time_us = sent_reg;
endmodule

// ----- rtl/ntpm_cell.sv -----
// Cell: one table slot, compares itself against the passing search token
`timescale 1ns / 1ps
module ntpm_cell (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic signed [ntpm_pkg::SPEED_W-1:0] wr_speed,
    input  logic [ntpm_pkg::TIME_W-1:0]   wr_time,
    input  logic                          set_matched,
    input  logic                          eval_en,
    input  logic [ntpm_pkg::IDX_W-1:0]    my_idx,
    input  logic signed [ntpm_pkg::SPEED_W-1:0] rx_speed,
    input  logic [ntpm_pkg::TIME_W-1:0]   rx_time,
    input  logic [ntpm_pkg::TOL_W-1:0]    tol,
    input  ntpm_pkg::srch_t               tok_in,
    output ntpm_pkg::srch_t               tok_out
);
    import ntpm_pkg::*;

    logic signed [SPEED_W-1:0] speed_reg;
    logic [TIME_W-1:0]         time_reg;
    logic                      matched_reg;
    logic signed [SPEED_W:0]   ds;
    logic [SPEED_W:0]          ads;
    logic [TIME_W-1:0]         dt;
    logic                      hit;
    srch_t                     tok_next, tok_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            speed_reg   <= wr_speed;
            time_reg    <= wr_time;
            matched_reg <= 1'b0;
        end else if (set_matched) begin
            matched_reg <= 1'b1;
        end
        tok_reg <= tok_next;
    end

    always_comb begin
        ds  = {speed_reg[SPEED_W-1], speed_reg} - {rx_speed[SPEED_W-1], rx_speed};
        ads = ds[SPEED_W] ? -ds : ds;
        dt  = (rx_time >= time_reg) ? rx_time - time_reg : time_reg - rx_time;
        hit = eval_en && !matched_reg && (ads < {{(SPEED_W+1-TOL_W){1'b0}}, tol});
        tok_next = tok_in;
        if (hit && (!tok_in.found || dt < tok_in.best_diff)) begin
            tok_next.found     = 1'b1;
            tok_next.best      = my_idx;
            tok_next.best_diff = dt;
            tok_next.best_time = time_reg;
        end
    end

    assign tok_out = tok_reg;
endmodule
